FILE: sv/stl_pkg.sv
// shared types, token kinds, character constants and classification functions
package stl_pkg;

    // token kinds
    localparam logic [5:0] K_IDENT = 6'd0;
    localparam logic [5:0] K_INT   = 6'd1;
    localparam logic [5:0] K_INC   = 6'd2;
    localparam logic [5:0] K_PLUS  = 6'd3;
    localparam logic [5:0] K_DEC   = 6'd4;
    localparam logic [5:0] K_MINUS = 6'd5;
    localparam logic [5:0] K_STAR  = 6'd6;
    localparam logic [5:0] K_SLASH = 6'd7;
    localparam logic [5:0] K_PCT   = 6'd8;
    localparam logic [5:0] K_EQEQ  = 6'd9;
    localparam logic [5:0] K_ASGN  = 6'd10;
    localparam logic [5:0] K_NEQ   = 6'd11;
    localparam logic [5:0] K_BANG  = 6'd12;
    localparam logic [5:0] K_SHL   = 6'd13;
    localparam logic [5:0] K_LT    = 6'd14;
    localparam logic [5:0] K_USHR  = 6'd15;
    localparam logic [5:0] K_SHR   = 6'd16;
    localparam logic [5:0] K_GT    = 6'd17;
    localparam logic [5:0] K_LAND  = 6'd18;
    localparam logic [5:0] K_AMP   = 6'd19;
    localparam logic [5:0] K_LOR   = 6'd20;
    localparam logic [5:0] K_BAR   = 6'd21;
    localparam logic [5:0] K_CARET = 6'd22;
    localparam logic [5:0] K_TILDE = 6'd23;
    localparam logic [5:0] K_DOT   = 6'd24;
    localparam logic [5:0] K_COMMA = 6'd25;
    localparam logic [5:0] K_LPAR  = 6'd26;
    localparam logic [5:0] K_RPAR  = 6'd27;
    localparam logic [5:0] K_LBRK  = 6'd28;
    localparam logic [5:0] K_RBRK  = 6'd29;
    localparam logic [5:0] K_LBRC  = 6'd30;
    localparam logic [5:0] K_RBRC  = 6'd31;
    localparam logic [5:0] K_COLON = 6'd32;
    localparam logic [5:0] K_QUEST = 6'd33;

    // characters
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;

    // kind of the token held open while the next byte decides it
    typedef enum logic [3:0] {
        P_NONE  = 4'd0,
        P_IDENT = 4'd1,
        P_INT   = 4'd2,
        P_PLUS  = 4'd3,
        P_MINUS = 4'd4,
        P_EQ    = 4'd5,
        P_BANG  = 4'd6,
        P_LT    = 4'd7,
        P_GT    = 4'd8,
        P_GTGT  = 4'd9,
        P_AMP   = 4'd10,
        P_BAR   = 4'd11
    } pend_t;

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= CH_0) && (ch <= CH_9);
    endfunction

    function automatic logic is_word_start(input logic [7:0] ch);
        return ((ch >= CH_LA) && (ch <= CH_LZ)) || ((ch >= CH_UA) && (ch <= CH_UZ))
            || (ch == CH_UNDER);
    endfunction

    function automatic logic is_word(input logic [7:0] ch);
        return is_word_start(ch) || is_digit(ch);
    endfunction

    function automatic logic is_space(input logic [7:0] ch);
        return (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    endfunction

    // byte that extends an operator prefix
    function automatic logic [7:0] dbl_byte(input pend_t pk);
        logic [7:0] r;
        unique case (pk)
            P_PLUS:  r = CH_PLUS;
            P_MINUS: r = CH_MINUS;
            P_EQ:    r = CH_EQ;
            P_BANG:  r = CH_EQ;
            P_LT:    r = CH_LT;
            P_GT:    r = CH_GT;
            P_GTGT:  r = CH_GT;
            P_AMP:   r = CH_AMP;
            P_BAR:   r = CH_BAR;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // kind when the prefix is extended
    function automatic logic [5:0] dbl_kind(input pend_t pk);
        logic [5:0] r;
        unique case (pk)
            P_PLUS:  r = K_INC;
            P_MINUS: r = K_DEC;
            P_EQ:    r = K_EQEQ;
            P_BANG:  r = K_NEQ;
            P_LT:    r = K_SHL;
            P_GT:    r = K_SHR;
            P_GTGT:  r = K_USHR;
            P_AMP:   r = K_LAND;
            P_BAR:   r = K_LOR;
            default: r = K_IDENT;
        endcase
        return r;
    endfunction

    // kind when nothing more joins the pending token
    function automatic logic [5:0] one_kind(input pend_t pk);
        logic [5:0] r;
        unique case (pk)
            P_INT:   r = K_INT;
            P_PLUS:  r = K_PLUS;
            P_MINUS: r = K_MINUS;
            P_EQ:    r = K_ASGN;
            P_BANG:  r = K_BANG;
            P_LT:    r = K_LT;
            P_GT:    r = K_GT;
            P_GTGT:  r = K_SHR;
            P_AMP:   r = K_AMP;
            P_BAR:   r = K_BAR;
            default: r = K_IDENT;
        endcase
        return r;
    endfunction

    // operator byte that may start a longer operator
    function automatic pend_t prefix_code(input logic [7:0] ch);
        pend_t r;
        unique case (ch)
            CH_PLUS:  r = P_PLUS;
            CH_MINUS: r = P_MINUS;
            CH_EQ:    r = P_EQ;
            CH_BANG:  r = P_BANG;
            CH_LT:    r = P_LT;
            CH_GT:    r = P_GT;
            CH_AMP:   r = P_AMP;
            CH_BAR:   r = P_BAR;
            default:  r = P_NONE;
        endcase
        return r;
    endfunction

    // single-byte punctuation, identifier kind means none
    function automatic logic [5:0] single_kind(input logic [7:0] ch);
        logic [5:0] r;
        unique case (ch)
            8'h2A:   r = K_STAR;
            8'h2F:   r = K_SLASH;
            8'h25:   r = K_PCT;
            8'h5E:   r = K_CARET;
            8'h7E:   r = K_TILDE;
            8'h2E:   r = K_DOT;
            8'h2C:   r = K_COMMA;
            8'h28:   r = K_LPAR;
            8'h29:   r = K_RPAR;
            8'h5B:   r = K_LBRK;
            8'h5D:   r = K_RBRK;
            8'h7B:   r = K_LBRC;
            8'h7D:   r = K_RBRC;
            8'h3A:   r = K_COLON;
            8'h3F:   r = K_QUEST;
            default: r = K_IDENT;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/stl_front.sv
// front end: byte classification, pending token tracking and position counters
module stl_front
    import stl_pkg::*;
#(
    parameter int OFFSET_BITS = 24,
    parameter int ROW_BITS    = 16,
    parameter int COL_BITS    = 16,
    parameter int LEN_BITS    = 8,
    parameter int REC_W       = 2 * (7 + ROW_BITS + COL_BITS + LEN_BITS + OFFSET_BITS) + 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             end_of_text,
    input  logic             q_full,
    output logic             q_push,
    output logic [REC_W-1:0] q_rec
);

    typedef struct packed {
        logic [5:0]             kind;
        logic [ROW_BITS-1:0]    row;
        logic [COL_BITS-1:0]    col;
        logic [LEN_BITS-1:0]    len;
        logic [OFFSET_BITS-1:0] off;
        logic                   bad;
    } tok_t;

    pend_t                  pend_reg, pend_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [ROW_BITS-1:0]    prow_reg, prow_next;
    logic [COL_BITS-1:0]    pcol_reg, pcol_next;
    logic [LEN_BITS-1:0]    plen_reg, plen_next;
    logic [OFFSET_BITS-1:0] byte_cnt_reg, byte_cnt_next;
    logic [ROW_BITS-1:0]    line_cnt_reg, line_cnt_next;
    logic [COL_BITS-1:0]    col_cnt_reg, col_cnt_next;

    logic  accept;
    logic  used;
    logic  a_v, b_v, c_v;
    tok_t  a_tok, b_tok, c_tok, t0, t1;
    pend_t pc;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign pc       = prefix_code(in_byte);

    // pending token update and result collection for one byte
    always_comb
    begin
        pend_next  = pend_reg;
        start_next = start_reg;
        prow_next  = prow_reg;
        pcol_next  = pcol_reg;
        plen_next  = plen_reg;
        used  = 1'b0;
        a_v   = 1'b0;
        b_v   = 1'b0;
        c_v   = 1'b0;
        a_tok = '0;
        b_tok = '0;
        c_tok = '0;

        // settle or extend what is pending
        unique case (pend_reg)
            P_IDENT, P_INT:
            begin
                if ((pend_reg == P_IDENT) ? is_word(in_byte) : is_digit(in_byte))
                begin
                    used = 1'b1;
                    if (plen_reg != '1)
                    begin
                        plen_next = plen_reg + 1'b1;
                    end
                end
                else
                begin
                    a_v       = 1'b1;
                    a_tok     = '{one_kind(pend_reg), prow_reg, pcol_reg, plen_reg,
                                  start_reg, 1'b0};
                    pend_next = P_NONE;
                end
            end
            P_PLUS, P_MINUS, P_EQ, P_BANG, P_LT, P_GT, P_GTGT, P_AMP, P_BAR:
            begin
                if (in_byte == dbl_byte(pend_reg))
                begin
                    used = 1'b1;
                    if (pend_reg == P_GT)
                    begin
                        pend_next = P_GTGT;
                        plen_next = LEN_BITS'(2);
                    end
                    else
                    begin
                        a_v       = 1'b1;
                        a_tok     = '{dbl_kind(pend_reg), prow_reg, pcol_reg,
                                      (pend_reg == P_GTGT) ? LEN_BITS'(3) : LEN_BITS'(2),
                                      start_reg, 1'b0};
                        pend_next = P_NONE;
                    end
                end
                else
                begin
                    a_v       = 1'b1;
                    a_tok     = '{one_kind(pend_reg), prow_reg, pcol_reg, plen_reg,
                                  start_reg, 1'b0};
                    pend_next = P_NONE;
                end
            end
            default:
            begin
                pend_next = P_NONE;
            end
        endcase

        // a byte not taken by the pending token starts its own
        if (!used && !is_space(in_byte))
        begin
            if (is_word_start(in_byte) || is_digit(in_byte) || (pc != P_NONE))
            begin
                pend_next  = is_word_start(in_byte) ? P_IDENT
                           : (is_digit(in_byte) ? P_INT : pc);
                start_next = byte_cnt_reg;
                prow_next  = line_cnt_reg;
                pcol_next  = col_cnt_reg;
                plen_next  = LEN_BITS'(1);
            end
            else
            begin
                b_v   = 1'b1;
                b_tok = '{single_kind(in_byte), line_cnt_reg, col_cnt_reg, LEN_BITS'(1),
                          byte_cnt_reg, (single_kind(in_byte) == K_IDENT)};
            end
        end

        // flush at end of text
        if (end_of_text && (pend_next != P_NONE))
        begin
            c_v       = 1'b1;
            c_tok     = '{one_kind(pend_next), prow_next, pcol_next, plen_next,
                          start_next, 1'b0};
            pend_next = P_NONE;
        end
    end

    // pack up to two results in order
    always_comb
    begin
        t0 = a_v ? a_tok : (b_v ? b_tok : c_tok);
        t1 = a_v ? (b_v ? b_tok : c_tok) : c_tok;
    end

    assign q_push = accept && (a_v || b_v || c_v);
    assign q_rec  = {((a_v && (b_v || c_v)) || (b_v && c_v)), t1, t0};

    // position counters
    always_comb
    begin
        byte_cnt_next = (byte_cnt_reg != '1) ? byte_cnt_reg + 1'b1 : byte_cnt_reg;
        if (in_byte == CH_NL)
        begin
            line_cnt_next = (line_cnt_reg != '1) ? line_cnt_reg + 1'b1 : line_cnt_reg;
            col_cnt_next  = '0;
        end
        else
        begin
            line_cnt_next = line_cnt_reg;
            col_cnt_next  = (col_cnt_reg != '1) ? col_cnt_reg + 1'b1 : col_cnt_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= P_NONE;
            byte_cnt_reg <= '0;
            line_cnt_reg <= '0;
            col_cnt_reg  <= '0;
        end
        else if (accept)
        begin
            pend_reg     <= pend_next;
            byte_cnt_reg <= byte_cnt_next;
            line_cnt_reg <= line_cnt_next;
            col_cnt_reg  <= col_cnt_next;
        end
    end

    // pending token payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            start_reg <= start_next;
            prow_reg  <= prow_next;
            pcol_reg  <= pcol_next;
            plen_reg  <= plen_next;
        end
    end

endmodule

FILE: sv/stl_queue.sv
// short queue of result records between front and back
module stl_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rptr_reg];

    // pointer and fill count
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

endmodule

FILE: sv/stl_back.sv
// back end: splits each record into tokens and drives the output register
module stl_back
#(
    parameter int OFFSET_BITS = 24,
    parameter int ROW_BITS    = 16,
    parameter int COL_BITS    = 16,
    parameter int LEN_BITS    = 8,
    parameter int REC_W       = 2 * (7 + ROW_BITS + COL_BITS + LEN_BITS + OFFSET_BITS) + 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [REC_W-1:0]       q_rec,
    input  logic                   q_empty,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [5:0]             token_kind,
    output logic [ROW_BITS-1:0]    token_row,
    output logic [COL_BITS-1:0]    token_col,
    output logic [LEN_BITS-1:0]    token_length,
    output logic [OFFSET_BITS-1:0] token_offset,
    output logic                   bad_char,
    output logic                   run_end
);

    typedef struct packed {
        logic [5:0]             kind;
        logic [ROW_BITS-1:0]    row;
        logic [COL_BITS-1:0]    col;
        logic [LEN_BITS-1:0]    len;
        logic [OFFSET_BITS-1:0] off;
        logic                   bad;
    } tok_t;

    typedef struct packed {
        logic two;
        tok_t t1;
        tok_t t0;
    } rec_t;

    rec_t rec;
    tok_t cur;
    tok_t out_reg;
    logic out_valid_reg, out_valid_next;
    logic run_end_reg;
    logic sel_reg, sel_next;
    logic load, last;

    assign rec  = rec_t'(q_rec);
    assign cur  = sel_reg ? rec.t1 : rec.t0;
    assign last = !rec.two || sel_reg;
    assign load = !q_empty && (!out_valid_reg || out_ready);

    assign q_pop = load && last;

    // token select and output valid
    always_comb
    begin
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            sel_next       = !last;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg     <= cur;
            run_end_reg <= last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign token_kind   = out_reg.kind;
    assign token_row    = out_reg.row;
    assign token_col    = out_reg.col;
    assign token_length = out_reg.len;
    assign token_offset = out_reg.off;
    assign bad_char     = out_reg.bad;
    assign run_end      = run_end_reg;

endmodule

FILE: sv/source_token_lexer.sv
// source_token_lexer: one byte per cycle in while the queue has room, tokens out through a registered output
// input: one byte accepted every cycle while the 4-record queue has room
// output: one token per cycle while out_ready is high; a byte that settles two tokens gives them one after the other
// result path: a byte's results are pushed into the queue, then loaded into the output register
// reset: asynchronous, clears pending token, line/column/byte counters, queue and out_valid
module source_token_lexer
    import stl_pkg::*;
#(
    parameter int OFFSET_BITS = 24,
    parameter int ROW_BITS    = 16,
    parameter int COL_BITS    = 16,
    parameter int LEN_BITS    = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_byte,
    input  logic                   end_of_text,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [5:0]             token_kind,
    output logic [ROW_BITS-1:0]    token_row,
    output logic [COL_BITS-1:0]    token_col,
    output logic [LEN_BITS-1:0]    token_length,
    output logic [OFFSET_BITS-1:0] token_offset,
    output logic                   bad_char,
    output logic                   run_end
);

    localparam int REC_W = 2 * (7 + ROW_BITS + COL_BITS + LEN_BITS + OFFSET_BITS) + 1;
    localparam int Q_DEPTH = 4;

    logic             q_push, q_pop, q_full, q_empty;
    logic [REC_W-1:0] q_wrec, q_rrec;

    // classify bytes and build result records
    stl_front #(
        .OFFSET_BITS (OFFSET_BITS),
        .ROW_BITS    (ROW_BITS),
        .COL_BITS    (COL_BITS),
        .LEN_BITS    (LEN_BITS),
        .REC_W       (REC_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_rec       (q_wrec)
    );

    // decoupling queue
    stl_queue #(
        .WIDTH (REC_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wrec),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rrec),
        .empty (q_empty)
    );

    // serialize records onto the output
    stl_back #(
        .OFFSET_BITS (OFFSET_BITS),
        .ROW_BITS    (ROW_BITS),
        .COL_BITS    (COL_BITS),
        .LEN_BITS    (LEN_BITS),
        .REC_W       (REC_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_rec        (q_rrec),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .token_row    (token_row),
        .token_col    (token_col),
        .token_length (token_length),
        .token_offset (token_offset),
        .bad_char     (bad_char),
        .run_end      (run_end)
    );

endmodule

FILE: dv/token_checker.sv
`timescale 1ns / 1ps
// token checker: predicts lexer tokens from accepted requests and compares every result
module token_checker
    import stl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        end_of_text,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [5:0]  token_kind,
    input  logic [15:0] token_row,
    input  logic [15:0] token_col,
    input  logic [7:0]  token_length,
    input  logic [23:0] token_offset,
    input  logic        bad_char,
    input  logic        run_end,
    output int          fail_count,
    output int          tokens_open
);

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] row;
        logic [15:0] col;
        logic [7:0]  len;
        logic [23:0] offset;
        logic        bad;
        logic        last;
    } token_t;

    token_t expected_tokens [$];
    token_t fresh [$];

    // lexer state as the checker sees it
    pend_t       held_kind;
    logic [23:0] held_start;
    logic [15:0] held_row;
    logic [15:0] held_col;
    logic [7:0]  held_len;
    logic [23:0] byte_pos;
    logic [15:0] line_pos;
    logic [15:0] col_pos;
    int          errs;

    function automatic logic word_head(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
    endfunction

    function automatic logic digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // operator bytes that may grow into a longer operator
    function automatic pend_t lead_code(input logic [7:0] c);
        case (c)
            "+":     return P_PLUS;
            "-":     return P_MINUS;
            "=":     return P_EQ;
            "!":     return P_BANG;
            "<":     return P_LT;
            ">":     return P_GT;
            "&":     return P_AMP;
            "|":     return P_BAR;
            default: return P_NONE;
        endcase
    endfunction

    // one-byte punctuation, ident kind when the byte is not one
    function automatic logic [5:0] punct_kind(input logic [7:0] c);
        case (c)
            "*":     return K_STAR;
            "/":     return K_SLASH;
            "%":     return K_PCT;
            "^":     return K_CARET;
            "~":     return K_TILDE;
            ".":     return K_DOT;
            ",":     return K_COMMA;
            "(":     return K_LPAR;
            ")":     return K_RPAR;
            "[":     return K_LBRK;
            "]":     return K_RBRK;
            "{":     return K_LBRC;
            "}":     return K_RBRC;
            ":":     return K_COLON;
            "?":     return K_QUEST;
            default: return K_IDENT;
        endcase
    endfunction

    function automatic logic [7:0] join_byte(input pend_t k);
        case (k)
            P_PLUS:          return "+";
            P_MINUS:         return "-";
            P_EQ, P_BANG:    return "=";
            P_LT:            return "<";
            P_GT, P_GTGT:    return ">";
            P_AMP:           return "&";
            P_BAR:           return "|";
            default:         return 8'h00;
        endcase
    endfunction

    function automatic logic [5:0] joined_kind(input pend_t k);
        case (k)
            P_PLUS:  return K_INC;
            P_MINUS: return K_DEC;
            P_EQ:    return K_EQEQ;
            P_BANG:  return K_NEQ;
            P_LT:    return K_SHL;
            P_GTGT:  return K_USHR;
            P_AMP:   return K_LAND;
            default: return K_LOR;
        endcase
    endfunction

    function automatic logic [5:0] lone_kind(input pend_t k);
        case (k)
            P_INT:   return K_INT;
            P_PLUS:  return K_PLUS;
            P_MINUS: return K_MINUS;
            P_EQ:    return K_ASGN;
            P_BANG:  return K_BANG;
            P_LT:    return K_LT;
            P_GT:    return K_GT;
            P_GTGT:  return K_SHR;
            P_AMP:   return K_AMP;
            P_BAR:   return K_BAR;
            default: return K_IDENT;
        endcase
    endfunction

    function automatic int field_bad(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic add_token(input logic [5:0] kind, input logic [15:0] row,
                             input logic [15:0] col, input logic [7:0] len,
                             input logic [23:0] offset, input logic bad);
        token_t t;
        t = '{kind: kind, row: row, col: col, len: len, offset: offset, bad: bad, last: 1'b0};
        fresh.push_back(t);
    endtask

    // emit the held token as it stands
    task automatic settle_held();
        if (held_kind != P_NONE)
            add_token(lone_kind(held_kind), held_row, held_col, held_len, held_start, 1'b0);
        held_kind = P_NONE;
    endtask

    // tokens caused by one source byte
    task automatic lex_byte(input logic [7:0] c, input logic eot);
        logic   used;
        token_t t;
        used = 1'b0;
        fresh.delete();

        // try to extend the held token
        if (held_kind == P_IDENT || held_kind == P_INT) begin
            if (held_kind == P_IDENT ? (word_head(c) || digit(c)) : digit(c)) begin
                if (held_len != 8'hFF)
                    held_len++;
                used = 1'b1;
            end
            else
                settle_held();
        end
        else if (held_kind != P_NONE) begin
            if (c == join_byte(held_kind)) begin
                used = 1'b1;
                if (held_kind == P_GT) begin
                    held_kind = P_GTGT;
                    held_len  = 8'd2;
                end
                else begin
                    add_token(joined_kind(held_kind), held_row, held_col,
                              held_kind == P_GTGT ? 8'd3 : 8'd2, held_start, 1'b0);
                    held_kind = P_NONE;
                end
            end
            else
                settle_held();
        end

        // start a token, emit punctuation or flag a bad byte
        if (!used && !blank(c)) begin
            if (word_head(c) || digit(c) || lead_code(c) != P_NONE) begin
                held_kind  = word_head(c) ? P_IDENT : (digit(c) ? P_INT : lead_code(c));
                held_start = byte_pos;
                held_row   = line_pos;
                held_col   = col_pos;
                held_len   = 8'd1;
            end
            else if (punct_kind(c) != K_IDENT)
                add_token(punct_kind(c), line_pos, col_pos, 8'd1, byte_pos, 1'b0);
            else
                add_token(K_IDENT, line_pos, col_pos, 8'd1, byte_pos, 1'b1);
        end

        // saturating position counters
        if (byte_pos != 24'hFFFFFF)
            byte_pos++;
        if (c == CH_NL) begin
            if (line_pos != 16'hFFFF)
                line_pos++;
            col_pos = 16'd0;
        end
        else if (col_pos != 16'hFFFF)
            col_pos++;

        if (eot)
            settle_held();

        if (fresh.size() > 0) begin
            t = fresh.pop_back();
            t.last = 1'b1;
            fresh.push_back(t);
        end
        foreach (fresh[i])
            expected_tokens.push_back(fresh[i]);
    endtask

    // predict on accepted requests, compare on accepted results
    always @(posedge clk or negedge rst_n) begin
        token_t want;
        if (!rst_n) begin
            held_kind  = P_NONE;
            held_start = '0;
            held_row   = '0;
            held_col   = '0;
            held_len   = '0;
            byte_pos   = '0;
            line_pos   = '0;
            col_pos    = '0;
            errs       = 0;
            expected_tokens.delete();
            fail_count  <= 0;
            tokens_open <= 0;
        end
        else begin
            if (in_valid && in_ready)
                lex_byte(in_byte, end_of_text);
            if (out_valid && out_ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("unexpected token: kind %0d row %0d col %0d offset %0d",
                           token_kind, token_row, token_col, token_offset);
                    errs++;
                end
                else begin
                    want = expected_tokens.pop_front();
                    errs += field_bad("token_kind", want.kind, token_kind);
                    errs += field_bad("token_row", want.row, token_row);
                    errs += field_bad("token_col", want.col, token_col);
                    errs += field_bad("token_length", want.len, token_length);
                    errs += field_bad("token_offset", want.offset, token_offset);
                    errs += field_bad("bad_char", want.bad, bad_char);
                    errs += field_bad("run_end", want.last, run_end);
                end
            end
            fail_count  <= errs;
            tokens_open <= expected_tokens.size();
        end
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// testbench top: source byte stimulus, result backpressure, watchdog and verdict
module tb;
    import stl_pkg::*;

    localparam int TEXT_BYTES     = 1950;
    localparam int STEADY_FROM    = 1750;
    localparam int HOLD_AT        = 500;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte     = 8'h00;
    logic        end_of_text = 1'b0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [5:0]  token_kind;
    logic [15:0] token_row;
    logic [15:0] token_col;
    logic [7:0]  token_length;
    logic [23:0] token_offset;
    logic        bad_char;
    logic        run_end;

    int   fail_count;
    int   tokens_open;
    int   sent_count  = 0;
    int   idle_cycles = 0;
    logic steady      = 1'b0;

    string op_text [32] = '{"++", "+", "--", "-", "*", "/", "%", "==", "=", "!=", "!",
        "<<", "<", ">>>", ">>", ">", "&&", "&", "||", "|", "^", "~", ".", ",",
        "(", ")", "[", "]", "{", "}", ":", "?"};
    logic [7:0] blank_set [6] = '{CH_SPACE, CH_TAB, CH_NL, CH_CR, 8'h0B, 8'h0C};

    always #4 clk = ~clk;

    source_token_lexer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .end_of_text  (end_of_text),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .token_row    (token_row),
        .token_col    (token_col),
        .token_length (token_length),
        .token_offset (token_offset),
        .bad_char     (bad_char),
        .run_end      (run_end)
    );

    token_checker i_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .end_of_text  (end_of_text),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .token_row    (token_row),
        .token_col    (token_col),
        .token_length (token_length),
        .token_offset (token_offset),
        .bad_char     (bad_char),
        .run_end      (run_end),
        .fail_count   (fail_count),
        .tokens_open  (tokens_open)
    );

    function automatic logic random_mark();
        return $urandom_range(0, 49) == 0;
    endfunction

    function automatic logic [7:0] word_char(input logic head);
        int k;
        k = head ? $urandom_range(0, 52) : $urandom_range(0, 62);
        if (k < 26)
            return 8'(CH_LA + k);
        else if (k < 52)
            return 8'(CH_UA + k - 26);
        else if (k == 52)
            return CH_UNDER;
        return 8'(CH_0 + k - 53);
    endfunction

    // one request, with a random idle burst ahead of it
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap_pct;
        case ((sent_count / 97) % 3)
            0:       gap_pct = 0;
            1:       gap_pct = 12;
            default: gap_pct = 40;
        endcase
        if (!steady && $urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_byte     <= b;
        end_of_text <= eot;
        do
            @(posedge clk);
        while (!in_ready);
        sent_count++;
    endtask

    task automatic send_text(input string s, input logic marks);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], marks ? random_mark() : 1'b0);
    endtask

    task automatic send_word(input int len);
        send_byte(word_char(1'b1), random_mark());
        for (int i = 1; i < len; i++)
            send_byte(word_char(1'b0), random_mark());
    endtask

    // stimulus and verdict
    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: the long operators >>>, ++, --, <<, &&, || and !=, nul and high bytes, flush at the end mark
        send_text("x_9 >>>=1\n++--<<&&||!=", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_GT, 1'b1);

        // one word long enough to saturate the length field
        send_word(270);

        // random token soup with blanks, noise and random end marks
        while (sent_count < TEXT_BYTES) begin
            if (sent_count >= STEADY_FROM)
                steady = 1'b1;
            case ($urandom_range(0, 9))
                0, 1, 2:
                    send_word($urandom_range(0, 39) == 0 ? $urandom_range(60, 300)
                                                         : $urandom_range(1, 8));
                3, 4:
                    repeat ($urandom_range(1, 6))
                        send_byte(8'(CH_0 + $urandom_range(0, 9)), random_mark());
                5, 6, 7:
                    send_text(op_text[$urandom_range(0, 31)], 1'b1);
                8:
                    send_byte(blank_set[$urandom_range(0, 5)], random_mark());
                default:
                    send_byte(8'($urandom_range(0, 255)), random_mark());
            endcase
            if ($urandom_range(0, 1) == 0)
                send_byte(blank_set[$urandom_range(0, 5)], random_mark());
        end
        in_valid <= 1'b0;

        // drain outstanding tokens
        @(posedge clk);
        while (tokens_open != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[source_token_lexer] OK");
        else
            $display("[source_token_lexer] ERROR");
        $finish;
    end

    // result side: random stalls plus one long hold-off to fill the block
    initial begin
        int unsigned ticks;
        int unsigned n;
        int unsigned stall_pct;
        logic        held_off;
        ticks    = 0;
        held_off = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            case ((ticks / 211) % 3)
                0:       stall_pct = 0;
                1:       stall_pct = 15;
                default: stall_pct = 45;
            endcase
            if (!steady && !held_off && ticks >= HOLD_AT) begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                ticks += HOLD_CYCLES;
            end
            else if (!steady && $urandom_range(0, 99) < stall_pct) begin
                n = $urandom_range(1, 6);
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
                ticks += n;
            end
            else begin
                out_ready <= 1'b1;
                @(posedge clk);
                ticks++;
            end
        end
    end

    // watchdog on cycles with no accepted request or result
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("[source_token_lexer] ERROR");
        $finish;
    end

endmodule

FILE: source_token_lexer.f
sv/stl_pkg.sv
sv/stl_front.sv
sv/stl_queue.sv
sv/stl_back.sv
sv/source_token_lexer.sv
dv/token_checker.sv
dv/tb.sv
